// ===== rtl/rgb555_hsv_adjust_assert.svh =====
// Assertion macros used by the checker file of the color adjust block.
`ifndef RGB555_HSV_ADJUST_ASSERT_SVH
`define RGB555_HSV_ADJUST_ASSERT_SVH

// Implication checked on every rising clock edge outside reset.
`define RHA_ASSERT_IMP(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Implication whose consequence is checked in the next cycle.
`define RHA_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== rtl/rha_pkg.sv =====
// ---------------------------------------------------------------------------
// rha_pkg
// Types and constants shared by the color adjust block.
// ---------------------------------------------------------------------------
package rha_pkg;

  localparam logic [4:0]         ValMax = 5'd31;
  localparam logic signed [13:0] HueFull = 14'sd1536;

  localparam logic [1:0] CFG_HUE = 2'd0;
  localparam logic [1:0] CFG_SAT = 2'd1;
  localparam logic [1:0] CFG_VAL = 2'd2;
  localparam logic [1:0] CFG_RSVD = 2'd3;

  // Classified color handed from the front part to the back part.
  typedef struct packed {
    logic        alpha;
    logic [2:0]  sector;   // 0 red max, 2 green max, 4 blue max
    logic        neg;      // difference is negative
    logic [4:0]  diff_mag; // |difference| of the two other channels
    logic [4:0]  delta;
    logic [4:0]  vmax;
  } rha_cls_t;

  // Reciprocal table: ceil(2^18 / d) for d = 1..31, entry 0 unused.
  // With 18 fraction bits the product stays exact for numerators up to 31*256.
  function automatic logic [18:0] recip(input logic [4:0] d);
    logic [18:0] res;
    case (d)
      5'd1:    res = 19'd262144;
      5'd2:    res = 19'd131072;
      5'd3:    res = 19'd87382;
      5'd4:    res = 19'd65536;
      5'd5:    res = 19'd52429;
      5'd6:    res = 19'd43691;
      5'd7:    res = 19'd37450;
      5'd8:    res = 19'd32768;
      5'd9:    res = 19'd29128;
      5'd10:   res = 19'd26215;
      5'd11:   res = 19'd23832;
      5'd12:   res = 19'd21846;
      5'd13:   res = 19'd20165;
      5'd14:   res = 19'd18725;
      5'd15:   res = 19'd17477;
      5'd16:   res = 19'd16384;
      5'd17:   res = 19'd15421;
      5'd18:   res = 19'd14564;
      5'd19:   res = 19'd13798;
      5'd20:   res = 19'd13108;
      5'd21:   res = 19'd12484;
      5'd22:   res = 19'd11916;
      5'd23:   res = 19'd11398;
      5'd24:   res = 19'd10923;
      5'd25:   res = 19'd10486;
      5'd26:   res = 19'd10083;
      5'd27:   res = 19'd9710;
      5'd28:   res = 19'd9363;
      5'd29:   res = 19'd9040;
      5'd30:   res = 19'd8739;
      5'd31:   res = 19'd8457;
      default: res = '0;
    endcase
    return res;
  endfunction

endpackage

// ===== rtl/rha_front.sv =====
// ---------------------------------------------------------------------------
// rha_front
// Accepts a color beat, finds max, min and the hue sector.
// ---------------------------------------------------------------------------
module rha_front (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_stall,
  input  logic [15:0]       in_pixel_in,
  output logic              cls_valid,
  input  logic              cls_stall,
  output rha_pkg::rha_cls_t cls_data
);
  import rha_pkg::*;

  logic [4:0] r, g, b, mx, mn;
  rha_cls_t   cls_nxt;
  rha_cls_t   data_r;
  logic       valid_r;

  assign r = in_pixel_in[4:0];
  assign g = in_pixel_in[9:5];
  assign b = in_pixel_in[14:10];

  always_comb begin
    mx = (r >= g) ? r : g;
    mx = (mx >= b) ? mx : b;
    mn = (r <= g) ? r : g;
    mn = (mn <= b) ? mn : b;
    cls_nxt.alpha = in_pixel_in[15];
    cls_nxt.vmax  = mx;
    cls_nxt.delta = mx - mn;
    if (mx == r) begin
      cls_nxt.sector = 3'd0;
      cls_nxt.neg = (g < b);
      cls_nxt.diff_mag = (g < b) ? b - g : g - b;
    end else if (mx == g) begin
      cls_nxt.sector = 3'd2;
      cls_nxt.neg = (b < r);
      cls_nxt.diff_mag = (b < r) ? r - b : b - r;
    end else begin
      cls_nxt.sector = 3'd4;
      cls_nxt.neg = (r < g);
      cls_nxt.diff_mag = (r < g) ? g - r : r - g;
    end
  end

  assign in_stall  = valid_r && cls_stall;
  assign cls_valid = valid_r;
  assign cls_data  = data_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (!in_stall) begin
      valid_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (!in_stall && in_valid) begin
      data_r <= cls_nxt;
    end
  end
endmodule

// ===== rtl/rha_fifo.sv =====
// ---------------------------------------------------------------------------
// rha_fifo
// Short queue between front and back parts.
// ---------------------------------------------------------------------------
module rha_fifo #(
  parameter int unsigned Depth = 4
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              wr_valid,
  output logic              wr_stall,
  input  rha_pkg::rha_cls_t wr_data,
  output logic              rd_valid,
  input  logic              rd_stall,
  output rha_pkg::rha_cls_t rd_data
);
  import rha_pkg::*;

  localparam int unsigned AW = (Depth > 1) ? $clog2(Depth) : 1;

  rha_cls_t mem_r [Depth];
  logic [AW-1:0] wp_r, rp_r;
  logic [AW:0]   cnt_r;
  logic wr_en, rd_en;

  assign wr_stall = (cnt_r == (AW+1)'(Depth));
  assign rd_valid = (cnt_r != '0);
  assign rd_data  = mem_r[rp_r];
  assign wr_en = wr_valid && !wr_stall;
  assign rd_en = rd_valid && !rd_stall;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r <= '0;
      rp_r <= '0;
      cnt_r <= '0;
    end else begin
      if (wr_en) begin
        wp_r <= (wp_r == AW'(Depth - 1)) ? '0 : wp_r + 1'b1;
      end
      if (rd_en) begin
        rp_r <= (rp_r == AW'(Depth - 1)) ? '0 : rp_r + 1'b1;
      end
      cnt_r <= cnt_r + (AW+1)'(wr_en) - (AW+1)'(rd_en);
    end
  end

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem_r[wp_r] <= wr_data;
    end
  end
endmodule

// ===== rtl/rha_back.sv =====
// ---------------------------------------------------------------------------
// rha_back
// Pipelined hue division, adjustment and conversion back to RGB555.
// ---------------------------------------------------------------------------
module rha_back (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              cls_valid,
  output logic              cls_stall,
  input  rha_pkg::rha_cls_t cls_data,
  input  logic signed [11:0] hue_off,
  input  logic [9:0]        sat_gain,
  input  logic [9:0]        val_gain,
  output logic              out_valid,
  input  logic              out_stall,
  output logic [15:0]       out_pixel_out
);
  import rha_pkg::*;

  // Pipeline enable: whole pipe moves unless the last stage is stalled.
  logic adv;
  logic v1_r, v2_r, v3_r, v4_r;
  assign adv = !(v4_r && out_stall);
  assign cls_stall = !adv;
  assign out_valid = v4_r;

  // Stage 1: quotients by reciprocal multiply.
  logic [31:0] hq_prod, sq_prod;
  logic [8:0]  hq, sq;
  logic [18:0] rd, rm;
  always_comb begin
    rd = recip(cls_data.delta);
    rm = recip(cls_data.vmax);
    hq_prod = {19'd0, cls_data.diff_mag, 8'd0} * {13'd0, rd};
    sq_prod = {19'd0, cls_data.delta, 8'd0} * {13'd0, rm};
    hq = hq_prod[26:18];
    sq = (cls_data.vmax == 5'd0) ? 9'd0 : sq_prod[26:18];
  end

  logic [8:0] hq1_r, s1_r;
  logic       neg1_r, a1_r, z1_r;
  logic [2:0] sec1_r;
  logic [4:0] v1v_r;
  always_ff @(posedge clk) begin
    if (adv) begin
      hq1_r <= hq;
      s1_r <= sq;
      neg1_r <= cls_data.neg;
      sec1_r <= cls_data.sector;
      a1_r <= cls_data.alpha;
      z1_r <= (cls_data.delta == 5'd0);
      v1v_r <= cls_data.vmax;
    end
  end

  // Stage 2: hue assembly, wrap, gains.
  logic signed [13:0] h0, hs;
  logic [10:0] hw;
  logic [18:0] sp, vp;
  logic [8:0]  s2;
  logic [4:0]  v2;
  always_comb begin
    h0 = {11'd0, sec1_r} <<< 8;
    h0 = neg1_r ? h0 - 14'(hq1_r) : h0 + 14'(hq1_r);
    if (z1_r) begin
      h0 = '0;
    end else if (h0 < 0) begin
      h0 = h0 + HueFull;
    end
    // The shifted hue spans -2048..3582, so up to two wraps are needed.
    hs = h0 + 14'(hue_off);
    if (hs < 0) begin
      hs = hs + HueFull;
    end
    if (hs < 0) begin
      hs = hs + HueFull;
    end
    if (hs >= HueFull) begin
      hs = hs - HueFull;
    end
    if (hs >= HueFull) begin
      hs = hs - HueFull;
    end
    hw = 11'(hs);
    sp = 19'(s1_r) * 19'(sat_gain);
    vp = 19'(v1v_r) * 19'(val_gain);
    s2 = (sp[18:8] > 11'd256) ? 9'd256 : 9'(sp[18:8]);
    v2 = (vp[18:8] > 11'(ValMax)) ? ValMax : 5'(vp[18:8]);
  end

  logic [10:0] h2_r;
  logic [8:0]  s2_r;
  logic [4:0]  vv2_r;
  logic        a2_r;
  always_ff @(posedge clk) begin
    if (adv) begin
      h2_r <= hw;
      s2_r <= s2;
      vv2_r <= v2;
      a2_r <= a1_r;
    end
  end

  // Stage 3: s times remainder terms.
  logic [7:0]  rem;
  logic [8:0]  sr, sc;
  logic [17:0] m1, m2;
  always_comb begin
    rem = h2_r[7:0];
    m1 = 18'(s2_r) * 18'(rem);
    m2 = 18'(s2_r) * (18'd256 - 18'(rem));
    sr = 9'(m1 >> 8);
    sc = 9'(m2 >> 8);
  end

  logic [8:0]  ps_r, qs_r, ts_r, s3_r;
  logic [4:0]  vv3_r;
  logic [2:0]  reg3_r;
  logic        a3_r;
  always_ff @(posedge clk) begin
    if (adv) begin
      ps_r <= 9'(10'd256 - 10'(s2_r));
      qs_r <= 9'(10'd256 - 10'(sr));
      ts_r <= 9'(10'd256 - 10'(sc));
      s3_r <= s2_r;
      vv3_r <= vv2_r;
      reg3_r <= 3'(h2_r[10:8]);
      a3_r <= a2_r;
    end
  end

  // Stage 4: channel values and routing.
  logic [13:0] pm, qm, tm;
  logic [4:0]  p, q, t, nr, ng, nb;
  always_comb begin
    pm = 14'(vv3_r) * 14'(ps_r);
    qm = 14'(vv3_r) * 14'(qs_r);
    tm = 14'(vv3_r) * 14'(ts_r);
    p = 5'(pm >> 8);
    q = 5'(qm >> 8);
    t = 5'(tm >> 8);
    if (s3_r == 9'd0) begin
      nr = vv3_r; ng = vv3_r; nb = vv3_r;
    end else begin
      case (reg3_r)
        3'd0: begin nr = vv3_r; ng = t; nb = p; end
        3'd1: begin nr = q; ng = vv3_r; nb = p; end
        3'd2: begin nr = p; ng = vv3_r; nb = t; end
        3'd3: begin nr = p; ng = q; nb = vv3_r; end
        3'd4: begin nr = t; ng = p; nb = vv3_r; end
        default: begin nr = vv3_r; ng = p; nb = q; end
      endcase
    end
  end

  logic [15:0] px4_r;
  always_ff @(posedge clk) begin
    if (adv) begin
      px4_r <= {a3_r, nb, ng, nr};
    end
  end
  assign out_pixel_out = px4_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
      v2_r <= 1'b0;
      v3_r <= 1'b0;
      v4_r <= 1'b0;
    end else if (adv) begin
      v1_r <= cls_valid;
      v2_r <= v1_r;
      v3_r <= v2_r;
      v4_r <= v3_r;
    end
  end
endmodule

// ===== rtl/rgb555_hsv_adjust.sv =====
// ---------------------------------------------------------------------------
// rgb555_hsv_adjust
// HSV hue, saturation and brightness adjustment of RGB555 palette colors.
// ---------------------------------------------------------------------------
// Channel  Ports                                 Direction
// input    in_valid, in_stall, in_pixel_in       beat in
// result   out_valid, out_stall, out_pixel_out   beat out
// config   cfg_we, cfg_index, cfg_data           write only
// One beat is accepted every cycle when the result side does not stall.
// A beat passes one front register, one queue entry and four back stages.
// The hue divider is a reciprocal table and one multiply, so nothing iterates.
// Reset clears the queue and pipe valid bits and loads the register defaults.
// A result stall holds the back pipe; the queue then fills before in_stall rises.
module rgb555_hsv_adjust #(
  parameter int unsigned QueueDepth = 4
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [15:0] in_pixel_in,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [15:0] out_pixel_out,
  input  logic        cfg_we,
  input  logic [1:0]  cfg_index,
  input  logic [11:0] cfg_data
);
  import rha_pkg::*;

  // Configuration registers; writes to index 3 are dropped.
  logic signed [11:0] hue_off_r;
  logic [9:0] sat_gain_r, val_gain_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      hue_off_r <= '0;
      sat_gain_r <= 10'd256;
      val_gain_r <= 10'd256;
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_HUE: hue_off_r <= cfg_data;
        CFG_SAT: sat_gain_r <= cfg_data[9:0];
        CFG_VAL: val_gain_r <= cfg_data[9:0];
        default: ;
      endcase
    end
  end

  // Front part classifies; the queue decouples it from the back part.
  logic     f_valid, f_stall, q_valid, q_stall;
  rha_cls_t f_data, q_data;

  rha_front u_front (
    .clk, .rst_n, .in_valid, .in_stall, .in_pixel_in,
    .cls_valid(f_valid), .cls_stall(f_stall), .cls_data(f_data)
  );

  rha_fifo #(.Depth(QueueDepth)) u_fifo (
    .clk, .rst_n,
    .wr_valid(f_valid), .wr_stall(f_stall), .wr_data(f_data),
    .rd_valid(q_valid), .rd_stall(q_stall), .rd_data(q_data)
  );

  rha_back u_back (
    .clk, .rst_n,
    .cls_valid(q_valid), .cls_stall(q_stall), .cls_data(q_data),
    .hue_off(hue_off_r), .sat_gain(sat_gain_r), .val_gain(val_gain_r),
    .out_valid, .out_stall, .out_pixel_out
  );
endmodule

// ===== rtl/rha_checker.sv =====
// ---------------------------------------------------------------------------
// rha_checker
// Port-level checks of the color adjust block.
// ---------------------------------------------------------------------------
`include "rgb555_hsv_adjust_assert.svh"

module rha_checker (
  input logic        clk,
  input logic        rst_n,
  input logic        in_valid,
  input logic        in_stall,
  input logic        out_valid,
  input logic        out_stall,
  input logic [15:0] out_pixel_out
);
  `RHA_ASSERT_NEXT(a_out_hold, clk, rst_n, out_valid && out_stall, out_valid && $stable(out_pixel_out), "stalled beat changed")
  `RHA_ASSERT_IMP(a_no_stall_idle, clk, rst_n, !out_valid, !in_stall, "input stalled, output empty")
  `RHA_ASSERT_IMP(a_out_known, clk, rst_n, out_valid, !$isunknown(out_pixel_out), "unknown result")
endmodule

bind rgb555_hsv_adjust rha_checker u_rha_checker (
  .clk, .rst_n, .in_valid, .in_stall, .out_valid, .out_stall, .out_pixel_out
);

// ===== tb/sv/rgb555_hsv_adjust_checker.sv =====
`timescale 1ns / 100ps
// ---------------------------------------------------------------------------
// rgb555_hsv_adjust_checker
// Watches both channels of the color adjust block and checks every result.
// Each accepted input beat is run through an integer HSV adjust predictor and
// queued; each accepted result beat is compared with the oldest prediction.
// ---------------------------------------------------------------------------
module rgb555_hsv_adjust_checker (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  input  logic        in_stall,
  input  logic [15:0] in_pixel_in,
  input  logic        out_valid,
  input  logic        out_stall,
  input  logic [15:0] out_pixel_out,
  input  logic        cfg_we,
  input  logic [1:0]  cfg_index,
  input  logic [11:0] cfg_data,
  output int          fail_count,
  output int          pending_colors,
  output int          result_count
);
  import rha_pkg::*;

  int          hue_off;
  int          sat_gain;
  int          val_gain;
  logic [15:0] adjusted_colors[$];

  function automatic logic [15:0] adjust_color(input logic [15:0] px);
    int r, g, b, mx, mn, dl, h, s, v, reg_n, rm, p, q, t, nr, ng, nb;
    r = px[4:0];
    g = px[9:5];
    b = px[14:10];
    mx = (r > g) ? r : g;
    mx = (mx > b) ? mx : b;
    mn = (r < g) ? r : g;
    mn = (mn < b) ? mn : b;
    dl = mx - mn;
    h = 0;
    s = (mx == 0) ? 0 : (dl * 256) / mx;
    v = mx;
    if (dl > 0) begin
      // Ties in the maximum go to red first, then green.
      if (mx == r) begin
        h = ((g - b) * 256) / dl;
        if (h < 0) h += 1536;
      end else if (mx == g) begin
        h = ((b - r) * 256) / dl + 512;
      end else begin
        h = ((r - g) * 256) / dl + 1024;
      end
    end
    h = (h + hue_off) % 1536;
    if (h < 0) h += 1536;
    s = (s * sat_gain) >>> 8;
    if (s > 256) s = 256;
    v = (v * val_gain) >>> 8;
    if (v > 31) v = 31;
    if (s == 0) begin
      nr = v; ng = v; nb = v;
    end else begin
      reg_n = h / 256;
      rm = h % 256;
      p = (v * (256 - s)) >>> 8;
      q = (v * (256 - ((s * rm) >>> 8))) >>> 8;
      t = (v * (256 - ((s * (256 - rm)) >>> 8))) >>> 8;
      case (reg_n)
        0: begin nr = v; ng = t; nb = p; end
        1: begin nr = q; ng = v; nb = p; end
        2: begin nr = p; ng = v; nb = t; end
        3: begin nr = p; ng = q; nb = v; end
        4: begin nr = t; ng = p; nb = v; end
        default: begin nr = v; ng = p; nb = q; end
      endcase
    end
    return {px[15], nb[4:0], ng[4:0], nr[4:0]};
  endfunction

  task automatic report_mismatch(input string what, input logic [15:0] got,
                                 input logic [15:0] want);
    $display("[%0t] MISMATCH %s: got %h expected %h", $realtime, what, got, want);
    fail_count++;
  endtask

  assign pending_colors = adjusted_colors.size();

  always @(posedge clk) begin
    logic [15:0] want;
    if (!rst_n) begin
      hue_off = 0;
      sat_gain = 256;
      val_gain = 256;
      fail_count = 0;
      result_count = 0;
      adjusted_colors.delete();
    end else begin
      // Results are compared before new beats are queued; the pipe is deep
      // enough that an input never leaves in the cycle it enters.
      if (out_valid && !out_stall) begin
        result_count++;
        if (adjusted_colors.size() == 0) begin
          report_mismatch("unexpected beat", out_pixel_out, 16'h0);
        end else begin
          want = adjusted_colors.pop_front();
          if (out_pixel_out[15] !== want[15])
            report_mismatch("alpha", out_pixel_out, want);
          if (out_pixel_out[4:0] !== want[4:0])
            report_mismatch("red", out_pixel_out, want);
          if (out_pixel_out[9:5] !== want[9:5])
            report_mismatch("green", out_pixel_out, want);
          if (out_pixel_out[14:10] !== want[14:10])
            report_mismatch("blue", out_pixel_out, want);
        end
      end
      if (in_valid && !in_stall) adjusted_colors.push_back(adjust_color(in_pixel_in));
      if (cfg_we) begin
        case (cfg_index)
          CFG_HUE: hue_off = $signed(cfg_data);
          CFG_SAT: sat_gain = cfg_data[9:0];
          CFG_VAL: val_gain = cfg_data[9:0];
          default: ;
        endcase
      end
    end
  end
endmodule

// ===== tb/sv/rgb555_hsv_adjust_tb.sv =====
`timescale 1ns / 100ps
// ---------------------------------------------------------------------------
// rgb555_hsv_adjust_tb
// Stimulus and verdict for the RGB555 HSV adjust block.
// Runs directed corner colors, then random color streams under several
// register settings with random idling on both channels; a separate checker
// predicts every result.
// ---------------------------------------------------------------------------
module rgb555_hsv_adjust_tb;
  import rha_pkg::*;

  localparam int WatchdogLimit = 4000;
  localparam int DrainCycles = 20;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_valid = 1'b0;
  logic        in_stall;
  logic [15:0] in_pixel_in = '0;
  logic        out_valid;
  logic        out_stall = 1'b0;
  logic [15:0] out_pixel_out;
  logic        cfg_we = 1'b0;
  logic [1:0]  cfg_index = CFG_HUE;
  logic [11:0] cfg_data = '0;

  int fail_count;
  int pending_colors;
  int result_count;
  int sent_count = 0;
  int idle_cycles = 0;
  // Random idling is switched off for the final stretch of the run.
  bit quiet_tail = 1'b0;
  // Set while the receiver holds off for a long stretch.
  bit hold_off = 1'b0;

  always #6 clk = ~clk;

  rgb555_hsv_adjust dut (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_stall(in_stall), .in_pixel_in(in_pixel_in),
    .out_valid(out_valid), .out_stall(out_stall), .out_pixel_out(out_pixel_out),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  rgb555_hsv_adjust_checker checker_i (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_stall(in_stall), .in_pixel_in(in_pixel_in),
    .out_valid(out_valid), .out_stall(out_stall), .out_pixel_out(out_pixel_out),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data),
    .fail_count(fail_count), .pending_colors(pending_colors),
    .result_count(result_count)
  );

  // Receiver: random stall bursts, or a long hold-off on request.
  always @(posedge clk) begin
    int burst;
    if (!rst_n) begin
      out_stall <= 1'b0;
      burst = 0;
    end else if (hold_off) begin
      out_stall <= 1'b1;
    end else if (burst > 0) begin
      burst--;
      out_stall <= 1'b1;
    end else if (!quiet_tail && $urandom_range(0, 5) == 0) begin
      burst = $urandom_range(0, 3);
      out_stall <= 1'b1;
    end else begin
      out_stall <= 1'b0;
    end
  end

  // Watchdog: counts cycles in which no beat moves on either channel.
  always @(posedge clk) begin
    if ((in_valid && !in_stall) || (out_valid && !out_stall)) begin
      idle_cycles <= 0;
    end else if (rst_n) begin
      idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= WatchdogLimit) begin
        $display("Watchdog expired with %0d results outstanding", pending_colors);
        $display("RESULT: ERROR");
        $finish;
      end
    end
  end

  task automatic write_reg(input logic [1:0] idx, input logic [11:0] val);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    @(posedge clk);
    cfg_we <= 1'b0;
  endtask

  // Waits until every predicted result has arrived, then lets the pipe settle.
  task automatic wait_drained();
    while (pending_colors != 0) @(posedge clk);
    repeat (DrainCycles) @(posedge clk);
  endtask

  // Offers one beat, with an optional random gap first, and waits for acceptance.
  task automatic send_color(input logic [15:0] px);
    int gap;
    if (!quiet_tail && $urandom_range(0, 4) == 0) begin
      gap = $urandom_range(1, 4);
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_pixel_in <= px;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    sent_count++;
  endtask

  // Random colors with random alpha, often with channel ties, grey or full red.
  function automatic logic [15:0] random_color();
    logic [15:0] px;
    px = 16'($urandom);
    case ($urandom_range(0, 5))
      0: px[14:10] = px[9:5];                       // ties between channels
      1: px[9:5] = px[4:0];
      2: px[14:0] = {3{px[4:0]}};                   // grey
      3: px[4:0] = 5'd31;                           // bright red maximum
      default: ;
    endcase
    return px;
  endfunction

  task automatic run_random(input int count);
    for (int i = 0; i < count; i++) send_color(random_color());
    in_valid <= 1'b0;
  endtask

  initial begin
    logic [15:0] corner_colors[$];
    corner_colors = '{16'h0000, 16'h8000, 16'h7FFF, 16'hFFFF, 16'h001F, 16'h03E0,
                      16'h7C00, 16'h03FF, 16'h7FE0, 16'h7C1F, 16'h0421, 16'h8010,
                      16'h0210, 16'h4010, 16'h3DEF, 16'h001E, 16'h7C01, 16'h03E1,
                      16'h0C1F, 16'h83F8, 16'h5A5A, 16'h2529};
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Default settings first, then every register gets its extremes.
    foreach (corner_colors[i]) send_color(corner_colors[i]);
    in_valid <= 1'b0;
    wait_drained();

    write_reg(CFG_HUE, 12'h7FF);
    write_reg(CFG_SAT, 12'd1023);
    write_reg(CFG_VAL, 12'd1023);
    foreach (corner_colors[i]) send_color(corner_colors[i]);
    run_random(250);
    wait_drained();

    write_reg(CFG_HUE, 12'h800);
    write_reg(CFG_SAT, 12'd0);
    write_reg(CFG_VAL, 12'd0);
    run_random(150);
    wait_drained();

    // Random settings; the top bits of the gain data are dropped by the block.
    for (int ph = 0; ph < 4; ph++) begin
      write_reg(CFG_HUE, 12'($urandom));
      write_reg(CFG_SAT, 12'($urandom_range(0, 4095)));
      write_reg(CFG_VAL, 12'($urandom_range(128, 600)));
      write_reg(CFG_RSVD, 12'($urandom));            // ignored index
      run_random(200);
      wait_drained();
    end

    // Long receiver hold-off while the sender keeps offering beats.
    write_reg(CFG_HUE, 12'd300);
    write_reg(CFG_SAT, 12'd300);
    write_reg(CFG_VAL, 12'd256);
    fork
      begin
        hold_off = 1'b1;
        repeat (60) @(posedge clk);
        hold_off = 1'b0;
      end
      run_random(100);
    join
    wait_drained();

    // Final stretch with no idling on either side.
    quiet_tail = 1'b1;
    write_reg(CFG_HUE, 12'hF00);
    write_reg(CFG_SAT, 12'd384);
    write_reg(CFG_VAL, 12'd200);
    run_random(180);
    wait_drained();

    $display("Sent %0d colors and checked %0d results across 9 register settings,",
             sent_count, result_count);
    $display("including gain and hue extremes, stalls and a long result hold-off.");
    if (fail_count == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end
endmodule
